// ===== rtl/pmct_pkg.sv =====
`timescale 1ns / 1ps
// package: constants and decode functions for the pot mouse cursor tracker
package pmct_pkg;

    localparam int POT_W  = 8;
    localparam int POS_W  = 10;
    localparam int STEP_W = 6;
    localparam int ACC_W  = 9;
    localparam int SUM_W  = 12;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_X_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_LIMIT = 2'd1;

    localparam logic [POS_W-1:0] X_LIMIT_RESET = 10'd319;
    localparam logic [POS_W-1:0] Y_LIMIT_RESET = 10'd199;

    localparam logic [POT_W-1:0] NOISE_FILL = 8'hc1;
    localparam logic [POT_W-1:0] NO_MOVE    = 8'hff;
    localparam logic [STEP_W-1:0] ACCEL_HI  = 6'd10;
    localparam logic [STEP_W-1:0] ACCEL_LO  = 6'd5;

    // 7-bit pot delta to signed step in -31..31
    function automatic logic signed [STEP_W-1:0] decode_step(
        input logic [POT_W-1:0] pot,
        input logic [POT_W-1:0] last
    );
        logic [POT_W-1:0] diff;
        logic [POT_W-1:0] fill;
        logic [POT_W-1:0] fill_inc;
        diff     = pot - last;
        fill     = {1'b1, diff[6:0]} | NOISE_FILL;
        fill_inc = fill + 8'd1;
        if (!diff[6])
            decode_step = $signed({1'b0, diff[5:1]});
        else if (fill == NO_MOVE)
            decode_step = '0;
        else
            decode_step = $signed(fill_inc[6:1]);
    endfunction

    // acceleration: times 5 above magnitude 10, times 3 above 5
    function automatic logic signed [ACC_W-1:0] accelerate(
        input logic signed [STEP_W-1:0] step
    );
        logic [STEP_W-1:0] mag;
        logic signed [ACC_W-1:0] wide;
        mag  = step[STEP_W-1] ? STEP_W'(-step) : STEP_W'(step);
        wide = {{(ACC_W-STEP_W){step[STEP_W-1]}}, step};
        if (mag > ACCEL_HI)
            accelerate = (wide <<< 2) + wide;
        else if (mag > ACCEL_LO)
            accelerate = (wide <<< 1) + wide;
        else
            accelerate = wide;
    endfunction

    // clamp a signed position sum to 0..limit
    function automatic logic [POS_W-1:0] clamp_pos(
        input logic signed [SUM_W-1:0] p,
        input logic [POS_W-1:0] limit
    );
        if (p[SUM_W-1])
            clamp_pos = '0;
        else if (p[SUM_W-2:0] > {1'b0, limit})
            clamp_pos = limit;
        else
            clamp_pos = p[POS_W-1:0];
    endfunction

endpackage

// ===== rtl/pot_mouse_cursor_tracker_unit.sv =====
`timescale 1ns / 1ps
// top level: pot mouse cursor tracker, input register, decode logic, result register
// path: an accepted sample goes from the input register into the result register and
//   transfers from there, held in the result register while the output stalls
// throughput: one sample per cycle; the input register stalls only while a
//   result waits and the output is stalled
// reset: rst_n clears valids, last pot values and positions, limits go to 319 / 199
module pot_mouse_cursor_tracker_unit
    import pmct_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pot_valid,
    output logic                 pot_stall,
    input  logic [POT_W-1:0]     pot_x,
    input  logic [POT_W-1:0]     pot_y,
    output logic                 cursor_valid,
    input  logic                 cursor_stall,
    output logic [POS_W-1:0]     cursor_x,
    output logic [POS_W-1:0]     cursor_y,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [POS_W-1:0]     cfg_data
);

    logic                    in_valid_reg;
    logic [POT_W-1:0]        in_x_reg;
    logic [POT_W-1:0]        in_y_reg;
    logic                    out_valid_reg;
    logic [POT_W-1:0]        last_x_reg;
    logic [POT_W-1:0]        last_y_reg;
    logic [POS_W-1:0]        pos_x_reg;
    logic [POS_W-1:0]        pos_y_reg;
    logic [POS_W-1:0]        x_limit_reg;
    logic [POS_W-1:0]        y_limit_reg;

    logic                    advance;
    logic signed [STEP_W-1:0] step_x;
    logic signed [STEP_W-1:0] step_y;
    logic signed [ACC_W-1:0]  acc_x;
    logic signed [ACC_W-1:0]  acc_y;
    logic signed [SUM_W-1:0]  sum_x;
    logic signed [SUM_W-1:0]  sum_y;
    logic [POS_W-1:0]        pos_x_next;
    logic [POS_W-1:0]        pos_y_next;
    logic [POT_W-1:0]        last_x_next;
    logic [POT_W-1:0]        last_y_next;

    // handshake: the input register moves on when the result register is free
    assign advance      = in_valid_reg && (!out_valid_reg || !cursor_stall);
    assign pot_stall    = in_valid_reg && !advance;
    assign cursor_valid = out_valid_reg;
    assign cursor_x     = pos_x_reg;
    assign cursor_y     = pos_y_reg;
    assign cfg_ready    = 1'b1;

    // decode, accelerate and clamp both axes
    always_comb
    begin
        step_x = decode_step(in_x_reg, last_x_reg);
        step_y = decode_step(in_y_reg, last_y_reg);
        acc_x  = accelerate(step_x);
        acc_y  = accelerate(step_y);
        sum_x  = $signed({2'b00, pos_x_reg}) + {{(SUM_W-ACC_W){acc_x[ACC_W-1]}}, acc_x};
        sum_y  = $signed({2'b00, pos_y_reg}) - {{(SUM_W-ACC_W){acc_y[ACC_W-1]}}, acc_y};
        pos_x_next  = clamp_pos(sum_x, x_limit_reg);
        pos_y_next  = clamp_pos(sum_y, y_limit_reg);
        last_x_next = (step_x != '0) ? in_x_reg : last_x_reg;
        last_y_next = (step_y != '0) ? in_y_reg : last_y_reg;
    end

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!pot_stall)
            in_valid_reg <= pot_valid;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (pot_valid && !pot_stall)
        begin
            in_x_reg <= pot_x;
            in_y_reg <= pot_y;
        end
    end

    // result register and tracker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            last_x_reg    <= '0;
            last_y_reg    <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                last_x_reg    <= last_x_next;
                last_y_reg    <= last_y_next;
                pos_x_reg     <= pos_x_next;
                pos_y_reg     <= pos_y_next;
            end
            else if (!cursor_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_limit_reg <= X_LIMIT_RESET;
            y_limit_reg <= Y_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_X_LIMIT: x_limit_reg <= cfg_data;
                REG_Y_LIMIT: y_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/pmct_checker.sv =====
`timescale 1ns / 1ps
// checker: port-level assertions for the cursor tracker, bound to the top level
module pmct_checker
    import pmct_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             pot_valid,
    input logic             pot_stall,
    input logic             cursor_valid,
    input logic             cursor_stall,
    input logic [POS_W-1:0] cursor_x,
    input logic [POS_W-1:0] cursor_y
);

    // a held result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        cursor_valid && cursor_stall |=> cursor_valid && $stable(cursor_x) && $stable(cursor_y))
        else $error("stalled cursor result changed or dropped");

    // the input side stalls only behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        pot_stall |-> cursor_valid && cursor_stall)
        else $error("input stalled while output free");

    // every input transfer is followed by a valid result
    assert property (@(posedge clk) disable iff (!rst_n)
        pot_valid && !pot_stall |-> ##2 cursor_valid)
        else $error("no result after input transfer");

    // a new result follows an input transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cursor_valid) |-> $past(pot_valid && !pot_stall, 2))
        else $error("result without input transfer");

endmodule

bind pot_mouse_cursor_tracker_unit pmct_checker u_pmct_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pot_valid    (pot_valid),
    .pot_stall    (pot_stall),
    .cursor_valid (cursor_valid),
    .cursor_stall (cursor_stall),
    .cursor_x     (cursor_x),
    .cursor_y     (cursor_y)
);

// ===== tb/tb_pot_mouse_cursor_tracker_unit.sv =====
`timescale 1ns / 1ps
// testbench: pot mouse cursor tracker, cursor predictor with scoreboard and handshake drivers

typedef struct packed {
    logic [pmct_pkg::POS_W-1:0] x;
    logic [pmct_pkg::POS_W-1:0] y;
} cursor_pos_t;

// tracks pot history and cursor position, holds expected cursor results in order
class cursor_scoreboard;
    logic [pmct_pkg::POT_W-1:0] last_x;
    logic [pmct_pkg::POT_W-1:0] last_y;
    logic [pmct_pkg::POS_W-1:0] pos_x;
    logic [pmct_pkg::POS_W-1:0] pos_y;
    logic [pmct_pkg::POS_W-1:0] lim_x;
    logic [pmct_pkg::POS_W-1:0] lim_y;
    cursor_pos_t expected_q[$];
    int errors;
    int checked;

    function new();
        last_x  = '0;
        last_y  = '0;
        pos_x   = '0;
        pos_y   = '0;
        lim_x   = 10'd319;
        lim_y   = 10'd199;
        errors  = 0;
        checked = 0;
    endfunction

    function void set_limit(logic [pmct_pkg::CFG_IDX_W-1:0] idx,
                            logic [pmct_pkg::POS_W-1:0] val);
        if (idx == pmct_pkg::REG_X_LIMIT)
            lim_x = val;
        else if (idx == pmct_pkg::REG_Y_LIMIT)
            lim_y = val;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // pot counter movement to a signed step of -31..31
    function int pot_step(logic [7:0] pot, logic [7:0] prev);
        logic [7:0] diff;
        logic [7:0] filled;
        logic signed [7:0] bumped;
        int wide;
        diff = pot - prev;
        if (!diff[6])
            return int'(diff[5:1]);
        // upper half: force the noise bit and the sign bits
        filled = {1'b0, diff[6:0]} | pmct_pkg::NOISE_FILL;
        if (filled == pmct_pkg::NO_MOVE)
            return 0;
        bumped = filled + 8'd1;
        wide = bumped;
        return wide / 2;
    endfunction

    // speed up larger movements
    function int boost(int s);
        int mag;
        mag = (s < 0) ? -s : s;
        if (mag > 10)
            return s * 5;
        if (mag > 5)
            return s * 3;
        return s;
    endfunction

    function logic [pmct_pkg::POS_W-1:0] clip(int p, logic [pmct_pkg::POS_W-1:0] lim);
        if (p < 0)
            return '0;
        if (p > int'(lim))
            return lim;
        return p[pmct_pkg::POS_W-1:0];
    endfunction

    // one accepted pot sample: advance the cursor and queue its position
    function void note_sample(logic [7:0] px, logic [7:0] py);
        int sx;
        int sy;
        int nx;
        int ny;
        cursor_pos_t c;
        sx = pot_step(px, last_x);
        sy = pot_step(py, last_y);
        nx = int'(pos_x);
        ny = int'(pos_y);
        if (sx != 0)
        begin
            nx += boost(sx);
            last_x = px;
        end
        if (sy != 0)
        begin
            ny -= boost(sy);
            last_y = py;
        end
        pos_x = clip(nx, lim_x);
        pos_y = clip(ny, lim_y);
        c.x = pos_x;
        c.y = pos_y;
        expected_q.push_back(c);
    endfunction

    // compare a delivered cursor result with the oldest expected one
    function void check_cursor(logic [pmct_pkg::POS_W-1:0] x, logic [pmct_pkg::POS_W-1:0] y);
        cursor_pos_t want;
        if (expected_q.size() == 0)
        begin
            errors++;
            $display("%0t: cursor x=%0d y=%0d arrived with no sample pending", $time, x, y);
            return;
        end
        want = expected_q.pop_front();
        checked++;
        if (x !== want.x)
        begin
            errors++;
            $display("%0t: cursor_x expected %0d actual %0d", $time, want.x, x);
        end
        if (y !== want.y)
        begin
            errors++;
            $display("%0t: cursor_y expected %0d actual %0d", $time, want.y, y);
        end
    endfunction
endclass

module tb_pot_mouse_cursor_tracker_unit;
    import pmct_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int RANDOM_PER_PHASE = 400;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 pot_valid = 1'b0;
    logic                 pot_stall;
    logic [POT_W-1:0]     pot_x = '0;
    logic [POT_W-1:0]     pot_y = '0;
    logic                 cursor_valid;
    logic                 cursor_stall = 1'b0;
    logic [POS_W-1:0]     cursor_x;
    logic [POS_W-1:0]     cursor_y;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [POS_W-1:0]     cfg_data = '0;

    cursor_scoreboard sb = new();
    int send_pct = 0;
    int recv_pct = 0;
    int samples = 0;
    int cfg_writes = 0;
    int cycle_count = 0;

    pot_mouse_cursor_tracker_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pot_valid    (pot_valid),
        .pot_stall    (pot_stall),
        .pot_x        (pot_x),
        .pot_y        (pot_y),
        .cursor_valid (cursor_valid),
        .cursor_stall (cursor_stall),
        .cursor_x     (cursor_x),
        .cursor_y     (cursor_y),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL pot_mouse_cursor_tracker_unit");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge clk)
        cursor_stall <= ($urandom_range(99) < recv_pct);

    // result monitor
    always @(posedge clk)
        if (rst_n && cursor_valid === 1'b1 && cursor_stall === 1'b0)
            sb.check_cursor(cursor_x, cursor_y);

    // one pot transfer, called at a falling edge, returns at a falling edge with valid high
    task automatic send_sample(input logic [7:0] px, input logic [7:0] py);
        while ($urandom_range(99) < send_pct)
        begin
            pot_valid <= 1'b0;
            @(negedge clk);
        end
        pot_valid <= 1'b1;
        pot_x <= px;
        pot_y <= py;
        @(posedge clk);
        while (pot_stall !== 1'b0)
            @(posedge clk);
        sb.note_sample(px, py);
        samples++;
        @(negedge clk);
    endtask

    // move each pot by a 7-bit amount from the last value that moved the cursor on that axis
    task automatic send_step(input logic [6:0] dx, input logic [6:0] dy);
        send_sample(sb.last_x + {1'b0, dx}, sb.last_y + {1'b0, dy});
    endtask

    // stop sending and wait until every cursor result is delivered
    task automatic wait_cursor_drain();
        pot_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() > 0)
            @(negedge clk);
    endtask

    task automatic cfg_transfer(input logic [CFG_IDX_W-1:0] idx, input logic [POS_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        sb.set_limit(idx, val);
        cfg_writes++;
        @(negedge clk);
    endtask

    task automatic write_limits(input logic [POS_W-1:0] x_lim, input logic [POS_W-1:0] y_lim);
        wait_cursor_drain();
        cfg_transfer(REG_X_LIMIT, x_lim);
        cfg_transfer(REG_Y_LIMIT, y_lim);
        cfg_valid <= 1'b0;
    endtask

    // mostly small wandering deltas, some full range and decode corners
    function automatic logic [6:0] rand_delta();
        int pick;
        pick = $urandom_range(9);
        if (pick <= 5)
            return $urandom_range(1) ? 7'($urandom_range(23)) : 7'($urandom_range(127, 104));
        if (pick <= 7)
            return 7'($urandom_range(127));
        if (pick == 8)
            return $urandom_range(1) ? 7'($urandom_range(127, 126)) : 7'($urandom_range(1));
        return $urandom_range(1) ? 7'($urandom_range(65, 64)) : 7'($urandom_range(63, 62));
    endfunction

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
                wait_cursor_drain();
            if ($urandom_range(9) == 0)
                send_sample(8'($urandom_range(255)), 8'($urandom_range(255)));
            else
                send_step(rand_delta(), rand_delta());
        end
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // decode corners and acceleration thresholds at reset limits
        send_step(7'h00, 7'h00);
        send_step(7'h01, 7'h7f);
        send_step(7'h7e, 7'h7e);
        send_step(7'h0a, 7'h0a);
        send_step(7'h0c, 7'h40);
        send_step(7'h14, 7'h41);
        send_step(7'h16, 7'h74);
        send_step(7'h3f, 7'h73);
        send_step(7'h40, 7'h6a);
        send_step(7'h69, 7'h3e);
        send_step(7'h7c, 7'h02);

        // climb to the top of the widest range
        write_limits(10'd1023, 10'd1023);
        repeat (8) send_step(7'h3e, 7'h40);

        // lowered limits pull the cursor down on the next sample
        write_limits(10'd0, 10'd0);
        send_step(7'h00, 7'h00);
        write_limits(10'd500, 10'd1);
        send_step(7'h3f, 7'h40);
        send_step(7'h40, 7'h3f);

        // sender lightly idle, receiver heavily stalled
        write_limits(10'($urandom_range(1023, 200)), 10'($urandom_range(1023, 100)));
        send_pct = 22;
        recv_pct = 64;
        run_random(RANDOM_PER_PHASE);

        // sender heavily idle, small limits
        write_limits(10'($urandom_range(60)), 10'($urandom_range(60)));
        send_pct = 64;
        recv_pct = 22;
        run_random(RANDOM_PER_PHASE);

        // full rate, widest limits
        write_limits(10'd1023, 10'd1023);
        send_pct = 0;
        recv_pct = 0;
        run_random(RANDOM_PER_PHASE);

        wait_cursor_drain();
        repeat (4) @(negedge clk);

        $display("covered %0d pot samples and %0d limit writes over three idle mixes",
                 samples, cfg_writes);
        $display("compared %0d cursor results, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS pot_mouse_cursor_tracker_unit");
        else
            $display("FAIL pot_mouse_cursor_tracker_unit");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/pmct_pkg.sv
rtl/pot_mouse_cursor_tracker_unit.sv
rtl/pmct_checker.sv
tb/tb_pot_mouse_cursor_tracker_unit.sv
